// ----- hdl/dmf_pkg.sv -----
// Shared constants, payload types and issue record for the diagonal majority filter.
package dmf_pkg;

  // Matrix and window limits
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_WINDOW = 16;
  localparam int RING_ROWS  = 2 * MAX_WINDOW + 1;

  // Field and internal widths
  localparam int PIX_W    = 8;
  localparam int WIN_W    = 5;
  localparam int SIZE_W   = 11;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 10;
  localparam int SPAN_W   = $clog2(2 * MAX_WINDOW + 1);
  localparam int SLOT_W   = $clog2(RING_ROWS);
  localparam int ADDR_W   = SLOT_W + COL_W;
  localparam int RING_DEPTH = RING_ROWS * (2 ** COL_W);
  localparam int PREFIX_W = 18;

  // Result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 3);

  // Configuration register indexes (word address bits)
  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_COLUMNS = 2'd1;
  localparam logic [1:0] REG_ROWS    = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic             decision;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last;
  } result_t;

  // Per-transaction record from the sequencer to the datapath
  typedef struct packed {
    logic [ADDR_W-1:0] prev_addr;
    logic [ADDR_W-1:0] old_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              use_prev;
    logic              emit;
    logic              zero_span;
    logic              last;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
  } issue_t;

endpackage

// ----- hdl/dmf_ram.sv -----
// Generic simple dual-read RAM: one write port, two registered read ports.
module dmf_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/dmf_seq.sv -----
// Raster position counters, ring slot tracking and ring address generation.
module dmf_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        frame_start,
  input  logic [dmf_pkg::WIN_W-1:0]   win_eff,
  input  logic [dmf_pkg::SIZE_W-1:0]  ncol,
  input  logic [dmf_pkg::SIZE_W-1:0]  nrow,
  output dmf_pkg::issue_t             iss
);

  logic [dmf_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [dmf_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [dmf_pkg::SLOT_W-1:0] head_r, head_nxt;

  logic [dmf_pkg::ROW_W-1:0]  r;
  logic [dmf_pkg::COL_W-1:0]  c;
  logic [dmf_pkg::SLOT_W-1:0] head;
  logic [dmf_pkg::SPAN_W-1:0] span;
  logic [dmf_pkg::SIZE_W-1:0] span_x, r_x, c_x;
  logic [dmf_pkg::SLOT_W-1:0] prev_slot, old_slot, span_s;

  // Current position; a frame start restarts the matrix at this element
  always_comb begin
    r    = frame_start ? '0 : row_r;
    c    = frame_start ? '0 : col_r;
    head = frame_start ? '0 : head_r;
    span   = {win_eff, 1'b0};
    span_s = dmf_pkg::SLOT_W'(span);
    span_x = dmf_pkg::SIZE_W'(span);
    r_x    = dmf_pkg::SIZE_W'(r);
    c_x    = dmf_pkg::SIZE_W'(c);
  end

  // Ring slots of the previous row and of the row one span back
  always_comb begin
    prev_slot = (head == '0) ? dmf_pkg::SLOT_W'(dmf_pkg::RING_ROWS - 1) : head - 1'b1;
    if (head >= span_s) begin
      old_slot = head - span_s;
    end else begin
      old_slot = head + dmf_pkg::SLOT_W'(dmf_pkg::RING_ROWS) - span_s;
    end
  end

  // Issue record for the datapath
  always_comb begin
    iss.prev_addr = {prev_slot, c - 1'b1};
    iss.old_addr  = {old_slot, c - dmf_pkg::COL_W'(span)};
    iss.wr_addr   = {head, c};
    iss.use_prev  = (r != '0) && (c != '0);
    iss.emit      = (r_x >= span_x) && (c_x >= span_x) && (r_x < nrow) && (c_x < ncol) &&
                    (span_x < nrow) && (span_x < ncol);
    iss.zero_span = (span == '0);
    iss.last      = (r_x == nrow - 1'b1) && (c_x == ncol - 1'b1);
    iss.out_row   = r - dmf_pkg::ROW_W'(span);
    iss.out_col   = c - dmf_pkg::COL_W'(span);
  end

  // Advance in raster order, wrapping at the end of a row and of the matrix
  always_comb begin
    row_nxt  = r;
    col_nxt  = c + 1'b1;
    head_nxt = head;
    if (c_x + 1'b1 >= ncol) begin
      col_nxt = '0;
      if (r_x + 1'b1 >= nrow) begin
        row_nxt  = '0;
        head_nxt = '0;
      end else begin
        row_nxt  = r + 1'b1;
        head_nxt = (head == dmf_pkg::SLOT_W'(dmf_pkg::RING_ROWS - 1)) ? '0 : head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      head_r <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      head_r <= head_nxt;
    end
  end

endmodule

// ----- hdl/dmf_outq.sv -----
// Small result queue that decouples the datapath from the output handshake.
module dmf_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  dmf_pkg::result_t             push_data,
  input  logic                         out_ready,
  output logic                         out_valid,
  output dmf_pkg::result_t             out_data,
  output logic [dmf_pkg::OUTQ_CW-1:0]  level
);

  dmf_pkg::result_t            q_r [dmf_pkg::OUTQ_DEPTH];
  logic [dmf_pkg::OUTQ_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [dmf_pkg::OUTQ_CW-1:0] cnt_r, cnt_nxt;
  logic                        pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign level     = cnt_r;

  // Pointer and occupancy update
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + dmf_pkg::OUTQ_CW'(push) - dmf_pkg::OUTQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_data;
    end
  end

endmodule

// ----- hdl/diagonal_majority_filter_unit.sv -----
// Top level: configuration registers, prefix-sum pipeline around the ring memory.
// Pipeline: an accepted transaction passes stage 1, stage 2 and then the result queue.
// Throughput: one element per cycle, set by the single write port of the ring memory;
// the input stalls only when the result queue plus two in-flight items would overflow.
// Reset: counters, pipeline valids and queue clear at once; the ring memory is not
// cleared and needs no clearing pass; window resets to 1, columns and rows to 1024.
module diagonal_majority_filter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dmf_pkg::pix_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dmf_pkg::result_t            out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [dmf_pkg::WIN_W-1:0]  window_r;
  logic [dmf_pkg::SIZE_W-1:0] columns_r, rows_r;
  logic [dmf_pkg::WIN_W-1:0]  win_eff;
  logic [dmf_pkg::SIZE_W-1:0] ncol, nrow;

  logic            accept;
  dmf_pkg::issue_t iss;

  logic                          s1_v_r;
  dmf_pkg::issue_t               s1_iss_r;
  logic [dmf_pkg::PIX_W-1:0]     s1_pix_r;
  logic [dmf_pkg::PREFIX_W-1:0]  rd_prev, rd_old, cur;

  logic                          s2_v_r;
  logic [dmf_pkg::PREFIX_W-1:0]  s2_cur_r, s2_old_r, diff;
  logic                          s2_zero_r, s2_last_r;
  logic [dmf_pkg::ROW_W-1:0]     s2_row_r;
  logic [dmf_pkg::COL_W-1:0]     s2_col_r;
  dmf_pkg::result_t              res;

  logic [dmf_pkg::OUTQ_CW-1:0]   q_level, pending;

  // Configuration port: written in the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= dmf_pkg::WIN_W'(1);
      columns_r <= dmf_pkg::SIZE_W'(1024);
      rows_r    <= dmf_pkg::SIZE_W'(1024);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        dmf_pkg::REG_WINDOW:  window_r  <= pwdata[dmf_pkg::WIN_W-1:0];
        dmf_pkg::REG_COLUMNS: columns_r <= pwdata[dmf_pkg::SIZE_W-1:0];
        dmf_pkg::REG_ROWS:    rows_r    <= pwdata[dmf_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dmf_pkg::REG_WINDOW:  prdata = 32'(window_r);
      dmf_pkg::REG_COLUMNS: prdata = 32'(columns_r);
      dmf_pkg::REG_ROWS:    prdata = 32'(rows_r);
      default:              prdata = '0;
    endcase
  end

  // Effective window and clamped matrix size
  always_comb begin
    win_eff = (window_r > dmf_pkg::WIN_W'(dmf_pkg::MAX_WINDOW)) ?
              dmf_pkg::WIN_W'(dmf_pkg::MAX_WINDOW) : window_r;
    if (columns_r == '0) begin
      ncol = dmf_pkg::SIZE_W'(1);
    end else if (columns_r > dmf_pkg::SIZE_W'(dmf_pkg::MAX_COLS)) begin
      ncol = dmf_pkg::SIZE_W'(dmf_pkg::MAX_COLS);
    end else begin
      ncol = columns_r;
    end
    if (rows_r == '0) begin
      nrow = dmf_pkg::SIZE_W'(1);
    end else if (rows_r > dmf_pkg::SIZE_W'(dmf_pkg::MAX_ROWS)) begin
      nrow = dmf_pkg::SIZE_W'(dmf_pkg::MAX_ROWS);
    end else begin
      nrow = rows_r;
    end
  end

  // Input credit: queue entries plus items still in the pipeline
  assign pending  = q_level + dmf_pkg::OUTQ_CW'(s1_v_r) + dmf_pkg::OUTQ_CW'(s2_v_r);
  assign in_ready = (pending < dmf_pkg::OUTQ_CW'(dmf_pkg::OUTQ_DEPTH));
  assign accept   = in_valid && in_ready;

  dmf_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .frame_start (in_data.frame_start),
    .win_eff     (win_eff),
    .ncol        (ncol),
    .nrow        (nrow),
    .iss         (iss)
  );

  // Ring of diagonal prefix sums: the write of an element lands at least two
  // transactions before any read of it, so no forwarding path is needed.
  dmf_ram #(
    .WIDTH (dmf_pkg::PREFIX_W),
    .DEPTH (dmf_pkg::RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (s1_v_r),
    .waddr   (s1_iss_r.wr_addr),
    .wdata   (cur),
    .re_a    (accept),
    .raddr_a (iss.prev_addr),
    .rdata_a (rd_prev),
    .re_b    (accept),
    .raddr_b (iss.old_addr),
    .rdata_b (rd_old)
  );

  // Stage 1: memory read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_iss_r <= iss;
      s1_pix_r <= in_data.pixel_value;
    end
  end

  // New prefix sum extends the diagonal chain from the previous row
  assign cur = dmf_pkg::PREFIX_W'(s1_pix_r) + (s1_iss_r.use_prev ? rd_prev : '0);

  // Stage 2: window difference and majority compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_iss_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_cur_r  <= cur;
      s2_old_r  <= rd_old;
      s2_zero_r <= s1_iss_r.zero_span;
      s2_last_r <= s1_iss_r.last;
      s2_row_r  <= s1_iss_r.out_row;
      s2_col_r  <= s1_iss_r.out_col;
    end
  end

  always_comb begin
    diff         = s2_cur_r - s2_old_r;
    res.decision = !s2_zero_r && (diff > dmf_pkg::PREFIX_W'(win_eff));
    res.out_row  = s2_row_r;
    res.out_col  = s2_col_r;
    res.last     = s2_last_r;
  end

  dmf_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_v_r),
    .push_data (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .level     (q_level)
  );

endmodule

// ----- test/diagonal_majority_filter_unit_tb.sv -----
// Self-checking testbench for the diagonal majority filter: directed table, then random frames.
module diagonal_majority_filter_unit_tb;
  import dmf_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 600;

  // Register byte addresses, one 32-bit word per register.
  localparam logic [3:0] ADDR_WINDOW  = {REG_WINDOW, 2'b00};
  localparam logic [3:0] ADDR_COLUMNS = {REG_COLUMNS, 2'b00};
  localparam logic [3:0] ADDR_ROWS    = {REG_ROWS, 2'b00};

  typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;

  // One row of the directed table: a register write or a pixel, with an optional
  // hand-written expectation.
  typedef struct packed {
    step_kind_t  kind;
    logic [3:0]  addr;
    logic [10:0] value;
    logic [7:0]  pixel;
    logic        fs;
    logic        typed;
    logic        hit;
    result_t     res;
  } dir_step_t;

  localparam result_t NO_RES = '0;
  localparam int DIR_LEN = 32;
  localparam dir_step_t DIR_TABLE [DIR_LEN] = '{
    // 3x3 with window 1: only (2,2) reports, for output (0,0); sum of x11 and x22 is 2.
    '{STEP_CFG, ADDR_WINDOW,  11'd1, 8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG, ADDR_COLUMNS, 11'd3, 8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG, ADDR_ROWS,    11'd3, 8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd255, 1'b1, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd0,   1'b0, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd255, 1'b0, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd0,   1'b0, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd1,   1'b0, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd0,   1'b0, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd0,   1'b0, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd0,   1'b0, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd1,   1'b0, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd0, 1'b1}},
    // Zero window on a 1x2 matrix: every element reports a zero decision, and the
    // counters wrap to a new matrix without frame_start.
    '{STEP_CFG, ADDR_WINDOW,  11'd0, 8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG, ADDR_COLUMNS, 11'd2, 8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG, ADDR_ROWS,    11'd1, 8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd7,   1'b1, 1'b1, 1'b1, '{1'b0, 10'd0, 10'd0, 1'b0}},
    '{STEP_PIX, 4'd0, 11'd0, 8'd200, 1'b0, 1'b1, 1'b1, '{1'b0, 10'd0, 10'd1, 1'b1}},
    '{STEP_PIX, 4'd0, 11'd0, 8'd1,   1'b0, 1'b1, 1'b1, '{1'b0, 10'd0, 10'd0, 1'b0}},
    '{STEP_PIX, 4'd0, 11'd0, 8'd0,   1'b1, 1'b1, 1'b1, '{1'b0, 10'd0, 10'd0, 1'b0}},
    '{STEP_PIX, 4'd0, 11'd0, 8'd0,   1'b0, 1'b1, 1'b1, '{1'b0, 10'd0, 10'd1, 1'b1}},
    // Oversized window with columns below range: filter wider than the matrix.
    '{STEP_CFG, ADDR_WINDOW,  11'd31,   8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG, ADDR_COLUMNS, 11'd0,    8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG, ADDR_ROWS,    11'd2047, 8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd255, 1'b1, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd0,   1'b0, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd128, 1'b0, 1'b1, 1'b0, NO_RES},
    // Columns above range and a span equal to the row count: still no results.
    '{STEP_CFG, ADDR_WINDOW,  11'd1,    8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG, ADDR_COLUMNS, 11'd2047, 8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_CFG, ADDR_ROWS,    11'd2,    8'd0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd3,   1'b1, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd255, 1'b0, 1'b1, 1'b0, NO_RES},
    '{STEP_PIX, 4'd0, 11'd0, 8'd0,   1'b0, 1'b1, 1'b0, NO_RES}
  };

  // DUT connections; the inputs driven here are all known from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pix_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  result_t     out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: configuration copy, counters and the diagonal prefix-sum ring.
  logic [WIN_W-1:0]    win_reg = 5'd1;
  logic [SIZE_W-1:0]   cols_reg = 11'd1024;
  logic [SIZE_W-1:0]   rows_reg = 11'd1024;
  int unsigned         row_cnt = 0;
  int unsigned         col_cnt = 0;
  int unsigned         ring_slot = 0;
  logic [PREFIX_W-1:0] diag_sum_ring [RING_ROWS][MAX_COLS];

  result_t     decision_queue [$];
  int          errors = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  diagonal_majority_filter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH at cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
  endtask

  // Predicts the result of one accepted pixel and advances the predictor state.
  function automatic bit predict_decision(input pix_in_t px, output result_t res);
    int unsigned w, span, ncol, nrow, r, c;
    logic [PREFIX_W-1:0] cur, diff;
    bit hit;
    w = (win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg;
    span = 2 * w;
    ncol = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
    nrow = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    res = '0;
    hit = 1'b0;
    if (px.frame_start) begin
      row_cnt = 0;
      col_cnt = 0;
      ring_slot = 0;
    end
    r = row_cnt;
    c = col_cnt % MAX_COLS;
    ring_slot = ring_slot % RING_ROWS;

    // Extend the diagonal chain from the element up and to the left.
    cur = PREFIX_W'(px.pixel_value);
    if (r > 0 && c > 0)
      cur = cur + diag_sum_ring[(ring_slot + RING_ROWS - 1) % RING_ROWS][c - 1];
    diag_sum_ring[ring_slot][c] = cur;

    // The window sum is the difference of two prefix sums 2w apart on the diagonal.
    if (r >= span && c >= span && r < nrow && c < ncol && span < nrow && span < ncol) begin
      diff = cur - diag_sum_ring[(ring_slot + RING_ROWS - span) % RING_ROWS][c - span];
      res.decision = (diff > w);
      res.out_row  = ROW_W'(r - span);
      res.out_col  = COL_W'(c - span);
      res.last     = (r == nrow - 1) && (c == ncol - 1);
      hit = 1'b1;
    end

    // Raster advance; the matrix end returns to (0,0).
    if (col_cnt + 1 >= ncol) begin
      col_cnt = 0;
      if (row_cnt + 1 >= nrow) begin
        row_cnt = 0;
        ring_slot = 0;
      end else begin
        row_cnt++;
        ring_slot = (ring_slot + 1) % RING_ROWS;
      end
    end else begin
      col_cnt++;
    end
    return hit;
  endfunction

  // Offers one pixel and returns at the edge that accepts the transaction.
  // in_valid stays high so a following item can be offered back to back.
  task automatic send_pixel(input logic [7:0] value, input logic fs);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel_value: value, frame_start: fs};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops the input and waits until every expected result is out and the pipe is empty.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decision_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register over APB, mirrors it in the predictor and reads it back.
  task automatic program_reg(input logic [3:0] addr, input logic [10:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (addr)
      ADDR_WINDOW:  win_reg = value[WIN_W-1:0];
      ADDR_COLUMNS: cols_reg = value;
      default:      rows_reg = value;
    endcase
    want = (addr == ADDR_WINDOW) ? 32'(win_reg) : 32'(value);
    // Read-back transaction.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) report_mismatch("register read-back", prdata, want);
    // The bus returns to idle before the next transaction.
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, long hold-offs on request, and result checking.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decision_queue.size() == 0) begin
        report_mismatch("result with nothing expected, out_col", out_data.out_col, 0);
      end else begin
        want = decision_queue.pop_front();
        if (out_data.decision !== want.decision)
          report_mismatch("decision", out_data.decision, want.decision);
        if (out_data.out_row !== want.out_row)
          report_mismatch("out_row", out_data.out_row, want.out_row);
        if (out_data.out_col !== want.out_col)
          report_mismatch("out_col", out_data.out_col, want.out_col);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stimulus.
  initial begin
    dir_step_t   step;
    pix_in_t     px;
    result_t     res;
    int          frame_idx;
    int          rand_items;
    int          w, ncol, nrow, total, k, sel;
    logic [10:0] wv, cv, rv;
    logic [7:0]  value;
    logic        fs;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (int i = 0; i < DIR_LEN; i++) begin
      step = DIR_TABLE[i];
      if (step.kind == STEP_CFG) begin
        drain_and_settle();
        program_reg(step.addr, step.value);
        @(posedge clk);
      end else begin
        send_pixel(step.pixel, step.fs);
        px = '{pixel_value: step.pixel, frame_start: step.fs};
        if (predict_decision(px, res) && !step.typed) decision_queue.push_back(res);
        if (step.typed && step.hit) decision_queue.push_back(step.res);
      end
    end

    // Random frames, mostly whole matrices of near-binary images.
    frame_idx = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS || frame_idx < 16) begin
      drain_and_settle();
      case (frame_idx % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase

      // Pick the matrix shape, with a few large and out-of-range settings.
      sel = $urandom_range(0, 9);
      if (frame_idx == 3) begin
        // A fixed shape with many results, so the long hold-off fills the block.
        wv = 11'd1;
        cv = 11'd8;
        rv = 11'd8;
      end else if (frame_idx == 5) begin
        wv = 11'($urandom_range(16, 31));
        cv = 11'($urandom_range(33, 36));
        rv = 11'd2;
      end else if (frame_idx == 9) begin
        wv = 11'd0;
        cv = 11'd2047;
        rv = 11'd2;
      end else if (frame_idx == 13) begin
        wv = 11'd1;
        cv = 11'd3;
        rv = 11'd2047;
      end else if (sel == 0) begin
        wv = 11'($urandom_range(0, 3));
        cv = 11'($urandom_range(0, 6));
        rv = 11'($urandom_range(0, 6));
      end else begin
        w  = $urandom_range(0, 3);
        wv = 11'(w);
        cv = 11'(2 * w + 1 + $urandom_range(0, 6));
        rv = 11'(2 * w + 1 + $urandom_range(0, 4));
      end
      program_reg(ADDR_WINDOW, wv);
      program_reg(ADDR_COLUMNS, cv);
      program_reg(ADDR_ROWS, rv);
      @(posedge clk);

      ncol = (cv == 0) ? 1 : ((cv > MAX_COLS) ? MAX_COLS : cv);
      nrow = (rv == 0) ? 1 : ((rv > MAX_ROWS) ? MAX_ROWS : rv);
      total = ncol * nrow;
      // Matrices with an oversized size register are cut short; the tall one
      // still runs past a full turn of the ring.
      if (frame_idx == 9) total = 40;
      else if (frame_idx == 13) total = 120;
      else if (frame_idx != 3 && $urandom_range(0, 9) == 0) total = $urandom_range(1, total);

      // Long receiver hold-off while the sender keeps offering.
      if (frame_idx == 3 || $urandom_range(0, 7) == 0) hold_reqs++;

      for (k = 0; k < total; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) value = 8'($urandom_range(0, 1));
        else if (sel < 85) value = 8'($urandom_range(0, 3));
        else value = 8'($urandom_range(0, 255));
        // A stray frame_start now and then restarts the matrix.
        fs = (k == 0) || ($urandom_range(0, 99) < 3);
        send_pixel(value, fs);
        px = '{pixel_value: value, frame_start: fs};
        if (predict_decision(px, res)) decision_queue.push_back(res);
        rand_items++;
      end
      frame_idx++;
    end

    // Let the last results come out, then give the pipe time to show any extras.
    in_valid <= 1'b0;
    @(posedge clk);
    while (decision_queue.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- diagonal_majority_filter_unit.f -----
hdl/dmf_pkg.sv
hdl/dmf_ram.sv
hdl/dmf_seq.sv
hdl/dmf_outq.sv
hdl/diagonal_majority_filter_unit.sv
test/diagonal_majority_filter_unit_tb.sv
